[rtl/bfa_pkg.sv]
// Shared package of the block fit allocator: default sizes, sum limits,
// placement policy, configuration register codes and sequencer states. No dependencies.
package bfa_pkg;

	// Default table depth and free-size width
	localparam int unsigned DEF_BLOCKS     = 16;
	localparam int unsigned DEF_SIZE_WIDTH = 16;

	// Running total of granted sizes saturates at this value
	localparam int unsigned SUM_W   = 20;
	localparam int unsigned SUM_MAX = 1048575;

	// Placement policy held in the fit_policy register
	typedef enum logic [1:0] {
		POL_BEST  = 2'd0,
		POL_FIRST = 2'd1,
		POL_NEXT  = 2'd2,
		POL_WORST = 2'd3
	} policy_t;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_FIT_POLICY    = 1'b0,
		CFG_BLOCKS_IN_USE = 1'b1
	} cfg_reg_t;

	// Sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

endpackage

[rtl/block_fit_allocator_core.sv]
// Block fit allocator: a load goes straight to the commit; no new item is taken until it.
// A request scans m active blocks through the single table read port, one per
// cycle, then drains the last read and commits; a commit waits for a free output slot.
// A waiting result sits in the output register while the next item is accepted.
// Reset clears the sequencer, total, rover and registers (policy best fit,
// all blocks in use); table contents stay undefined until loaded.
module block_fit_allocator_core
	import bfa_pkg::*;
#(
	parameter int unsigned BLOCKS     = DEF_BLOCKS,
	parameter int unsigned SIZE_WIDTH = DEF_SIZE_WIDTH,
	localparam int unsigned IDX_W     = $clog2(BLOCKS),
	localparam int unsigned CNT_W     = $clog2(BLOCKS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [0:0]            cfg_index,
	input  logic [CNT_W-1:0]      cfg_data,
	// input items
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  kind,
	input  logic [IDX_W-1:0]      block_number,
	input  logic [SIZE_WIDTH-1:0] size_value,
	input  logic                  last_request,
	// result items
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  granted,
	output logic [IDX_W-1:0]      chosen_block,
	output logic [SIZE_WIDTH-1:0] space_left,
	output logic [SUM_W-1:0]      total_used
);

	policy_t               policy_q;
	logic [CNT_W-1:0]      count_q;
	logic                  out_valid_q;
	logic                  slot_free;
	logic                  rd_en, wr_en;
	logic [IDX_W-1:0]      rd_addr, wr_addr;
	logic [SIZE_WIDTH-1:0] rd_data, wr_data;
	logic                  res_valid, res_granted;
	logic [IDX_W-1:0]      res_block;
	logic [SIZE_WIDTH-1:0] res_left;
	logic [SUM_W-1:0]      res_total;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_BEST;
			count_q  <= CNT_W'(BLOCKS);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FIT_POLICY:    policy_q <= policy_t'(cfg_data[1:0]);
				CFG_BLOCKS_IN_USE: count_q  <= cfg_data;
				default:           ;
			endcase
		end
	end

	bfa_table #(
		.DEPTH (BLOCKS),
		.WIDTH (SIZE_WIDTH)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	bfa_ctrl #(
		.BLOCKS     (BLOCKS),
		.SIZE_WIDTH (SIZE_WIDTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.policy        (policy_q),
		.blocks_in_use (count_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.block_number  (block_number),
		.size_value    (size_value),
		.last_request  (last_request),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.slot_free     (slot_free),
		.res_valid     (res_valid),
		.res_granted   (res_granted),
		.res_block     (res_block),
		.res_left      (res_left),
		.res_total     (res_total)
	);

	// Output register: free when empty or being taken
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result payload until taken
	always_ff @(posedge clk) begin
		if (res_valid) begin
			granted      <= res_granted;
			chosen_block <= res_block;
			space_left   <= res_left;
			total_used   <= res_total;
		end
	end

	assign out_valid = out_valid_q;

	// A commit never overwrites a result still waiting
	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> slot_free)
		else $error("result committed into a full output register");

	// After a commit the block takes the next item
	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !in_stall)
		else $error("block not ready after commit");

	// An accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("block ready right after accepting an item");

endmodule

[rtl/bfa_table.sv]
// Free-space table of the block fit allocator: one write port and one read
// port with registered read data. Depends on nothing.
module bfa_table #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 16,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read one entry, data valid the next cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/bfa_ctrl.sv]
// Sequencer of the block fit allocator: for a request scans the free-space table one entry
// a cycle, picks a block by policy and commits the update; a load commits directly. Uses bfa_pkg.
module bfa_ctrl
	import bfa_pkg::*;
#(
	parameter int unsigned BLOCKS     = DEF_BLOCKS,
	parameter int unsigned SIZE_WIDTH = DEF_SIZE_WIDTH,
	localparam int unsigned IDX_W     = $clog2(BLOCKS),
	localparam int unsigned CNT_W     = $clog2(BLOCKS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  policy_t               policy,
	input  logic [CNT_W-1:0]      blocks_in_use,
	// input items
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  kind,
	input  logic [IDX_W-1:0]      block_number,
	input  logic [SIZE_WIDTH-1:0] size_value,
	input  logic                  last_request,
	// table ports
	output logic                  rd_en,
	output logic [IDX_W-1:0]      rd_addr,
	input  logic [SIZE_WIDTH-1:0] rd_data,
	output logic                  wr_en,
	output logic [IDX_W-1:0]      wr_addr,
	output logic [SIZE_WIDTH-1:0] wr_data,
	// result toward the output register
	input  logic                  slot_free,
	output logic                  res_valid,
	output logic                  res_granted,
	output logic [IDX_W-1:0]      res_block,
	output logic [SIZE_WIDTH-1:0] res_left,
	output logic [SUM_W-1:0]      res_total
);

	localparam int unsigned ADD_W = ((SUM_W > SIZE_WIDTH) ? SUM_W : SIZE_WIDTH) + 1;

	state_t                state_q, state_d;
	logic                  kind_q, last_q;
	logic [IDX_W-1:0]      bnum_q;
	logic [SIZE_WIDTH-1:0] size_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      addr_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      addr_s1;
	logic                  found_q;
	logic [IDX_W-1:0]      sel_q;
	logic [SIZE_WIDTH-1:0] selval_q;
	logic [IDX_W-1:0]      rover_q;
	logic [SUM_W-1:0]      used_q;

	logic [CNT_W-1:0]      m_cnt;
	logic [IDX_W-1:0]      start_addr;
	logic                  accept, scan_last, addr_wrap, take, bnum_ok, commit;
	logic [ADD_W-1:0]      sum_wide;
	logic [SUM_W-1:0]      sum_sat;

	// Clamp the active block count to one..BLOCKS
	always_comb begin
		if (blocks_in_use == '0) begin
			m_cnt = CNT_W'(1);
		end else if (blocks_in_use > CNT_W'(BLOCKS)) begin
			m_cnt = CNT_W'(BLOCKS);
		end else begin
			m_cnt = blocks_in_use;
		end
	end

	// Next fit starts at the rover when it lies inside the active blocks
	assign start_addr = (policy == POL_NEXT && CNT_W'(rover_q) < m_cnt) ? rover_q : '0;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign scan_last = (cnt_q == m_cnt - CNT_W'(1));
	assign addr_wrap = (CNT_W'(addr_q) == m_cnt - CNT_W'(1));
	assign bnum_ok   = ((IDX_W + 1)'(bnum_q) < (IDX_W + 1)'(BLOCKS));
	assign commit    = (state_q == ST_COMMIT) && slot_free;

	// Issue one table read per scan cycle
	assign rd_en   = (state_q == ST_SCAN);
	assign rd_addr = addr_q;

	// Compare a returned entry against the current pick
	assign take = vld_s1 && (rd_data >= size_q) &&
		(!found_q ||
		 (policy == POL_BEST  && rd_data < selval_q) ||
		 (policy == POL_WORST && rd_data > selval_q));

	// Saturating running total
	assign sum_wide = ADD_W'(used_q) + ADD_W'(size_q);
	assign sum_sat  = (sum_wide > ADD_W'(SUM_MAX)) ? SUM_W'(SUM_MAX) : SUM_W'(sum_wide);

	// Commit: write back and build the result
	always_comb begin
		res_valid   = commit;
		res_granted = 1'b0;
		res_block   = '0;
		res_left    = '0;
		res_total   = used_q;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = '0;
		if (!kind_q) begin
			res_block = bnum_q;
			wr_en     = commit && bnum_ok;
			wr_addr   = bnum_q;
			wr_data   = size_q;
			if (bnum_ok) begin
				res_left = size_q;
			end
		end else if (found_q) begin
			res_granted = 1'b1;
			res_block   = sel_q;
			res_left    = selval_q - size_q;
			res_total   = sum_sat;
			wr_en       = commit;
			wr_addr     = sel_q;
			wr_data     = selval_q - size_q;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = in_valid && kind ? ST_SCAN : ST_COMMIT;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_COMMIT;
			ST_COMMIT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
			rover_q <= '0;
			used_q  <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == ST_SCAN);
			if (accept) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
			if (commit) begin
				if (last_q) begin
					rover_q <= '0;
					used_q  <= '0;
				end else begin
					used_q <= res_total;
					if (res_granted) begin
						rover_q <= sel_q;
					end
				end
			end
		end
	end

	// Item and scan payload
	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		if (accept) begin
			kind_q <= kind;
			bnum_q <= block_number;
			size_q <= size_value;
			last_q <= last_request;
			cnt_q  <= '0;
			addr_q <= start_addr;
		end else if (state_q == ST_SCAN) begin
			cnt_q  <= cnt_q + CNT_W'(1);
			addr_q <= addr_wrap ? '0 : addr_q + IDX_W'(1);
		end
		if (take) begin
			sel_q    <= addr_s1;
			selval_q <= rd_data;
		end
	end

endmodule
